[hdl/nnu_pkg.sv]
// Shared types and constants for the nearest-neighbor upscaler.
`default_nettype none
package nnu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_REG_W  = 11;
  localparam int SCALE_REG_W = 4;
  localparam int ADDR_W     = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_SCALE      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic base;
    logic step;
  } nnu_cmd_t;

  typedef struct packed {
    logic last;
  } nnu_sts_t;

endpackage
`default_nettype wire

[hdl/nnu_in_if.sv]
// Source pixel request channel.
`default_nettype none
interface nnu_in_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

[hdl/nnu_out_if.sv]
// Destination write request channel.
`default_nettype none
interface nnu_out_if #(
  parameter int PIXEL_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [nnu_pkg::ADDR_W-1:0] dest_addr;
  logic [PIXEL_BITS-1:0]     pixel_out;
  logic                      last_of_run;

  modport source (output valid, output dest_addr, output pixel_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input dest_addr, input pixel_out, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

[hdl/nnu_cfg_if.sv]
// Configuration register write channel.
`default_nettype none
interface nnu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nnu_pkg::CFG_IDX_W-1:0]  index;
  logic [nnu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/nearest_neighbor_upscaler.sv]
// Top level: nearest-neighbor integer upscaler.
// Takes one source pixel per request in row-major order and issues scale x scale
// write requests for it, each with its address in the scaled frame
// (row width = source width x scale); the final write of each pixel has
// last_of_run set. For each pixel the block has the accepting cycle, the address
// setup (row, column and width products, then the base address) and the writes,
// one per cycle unless the output stalls, from the replica counters into the
// single output register. A new pixel is accepted only after the last write of
// the previous one is taken. Register writes are accepted at any time (ready is
// tied high) and must only be issued while the block is idle.
`default_nettype none
module nearest_neighbor_upscaler #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_SCALE  = 8,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nnu_in_if.sink     in_if,
  nnu_out_if.source  out_if,
  nnu_cfg_if.sink    cfg_if
);
  import nnu_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [CW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [SW-1:0] scale_eff;
  nnu_cmd_t      cmd;
  nnu_sts_t      sts;

  assign cfg_if.ready = 1'b1;

  nnu_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE),
    .CW        (CW),
    .HW        (HW),
    .SW        (SW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_if.valid),
    .wr_index  (cfg_if.index),
    .wr_data   (cfg_if.data),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .scale_eff (scale_eff)
  );

  nnu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  nnu_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE),
    .PIXEL_BITS(PIXEL_BITS),
    .CW        (CW),
    .HW        (HW),
    .SW        (SW)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .scale_eff  (scale_eff),
    .pixel_in   (in_if.pixel_in),
    .dest_addr  (out_if.dest_addr),
    .pixel_out  (out_if.pixel_out),
    .last_of_run(out_if.last_of_run)
  );

endmodule
`default_nettype wire

[hdl/nnu_cfg_regs.sv]
// Configuration registers with range clamping.
`default_nettype none
module nnu_cfg_regs #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_SCALE  = 8,
  parameter int CW = $clog2(MAX_WIDTH + 1),
  parameter int HW = $clog2(MAX_HEIGHT + 1),
  parameter int SW = $clog2(MAX_SCALE + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [nnu_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [nnu_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [CW-1:0]                       width_eff,
  output logic [HW-1:0]                       height_eff,
  output logic [SW-1:0]                       scale_eff
);
  import nnu_pkg::*;

  logic [DIM_REG_W-1:0]   src_width_r;
  logic [DIM_REG_W-1:0]   src_height_r;
  logic [SCALE_REG_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_REG_W'(1024);
      src_height_r <= DIM_REG_W'(1024);
      scale_r      <= SCALE_REG_W'(2);
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_SRC_WIDTH:  src_width_r  <= wr_data[DIM_REG_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= wr_data[DIM_REG_W-1:0];
        REG_SCALE:      scale_r      <= wr_data[SCALE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r == '0)                      width_eff = CW'(1);
    else if (32'(src_width_r) > 32'(MAX_WIDTH)) width_eff = CW'(MAX_WIDTH);
    else                                        width_eff = CW'(src_width_r);

    if (src_height_r == '0)                       height_eff = HW'(1);
    else if (32'(src_height_r) > 32'(MAX_HEIGHT)) height_eff = HW'(MAX_HEIGHT);
    else                                          height_eff = HW'(src_height_r);

    if (scale_r == '0)                      scale_eff = SW'(1);
    else if (32'(scale_r) > 32'(MAX_SCALE)) scale_eff = SW'(MAX_SCALE);
    else                                    scale_eff = SW'(scale_r);
  end

endmodule
`default_nettype wire

[hdl/nnu_ctrl.sv]
// Sequencer: accept, address setup, replica emission.
`default_nettype none
module nnu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nnu_pkg::nnu_cmd_t      cmd,
  input  wire nnu_pkg::nnu_sts_t sts
);
  import nnu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_EMIT;
      ST_EMIT: if (out_ready && sts.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    cmd.load = in_ready && in_valid;
    cmd.mul  = (state_r == ST_MUL);
    cmd.base = (state_r == ST_BASE);
    cmd.step = out_valid && out_ready && !sts.last;
  end

endmodule
`default_nettype wire

[hdl/nnu_dpath.sv]
// Position counters, address arithmetic and replica counters.
`default_nettype none
module nnu_dpath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_SCALE  = 8,
  parameter int PIXEL_BITS = 8,
  parameter int CW = $clog2(MAX_WIDTH + 1),
  parameter int HW = $clog2(MAX_HEIGHT + 1),
  parameter int SW = $clog2(MAX_SCALE + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nnu_pkg::nnu_cmd_t           cmd,
  output nnu_pkg::nnu_sts_t                sts,
  input  wire logic [CW-1:0]               width_eff,
  input  wire logic [HW-1:0]               height_eff,
  input  wire logic [SW-1:0]               scale_eff,
  input  wire logic [PIXEL_BITS-1:0]       pixel_in,
  output logic [nnu_pkg::ADDR_W-1:0]       dest_addr,
  output logic [PIXEL_BITS-1:0]            pixel_out,
  output logic                             last_of_run
);
  import nnu_pkg::*;

  localparam int RSW = HW + SW;
  localparam int DWW = CW + SW;
  localparam int PW  = RSW + DWW;

  logic [HW-1:0]         src_row_r;
  logic [CW-1:0]         src_col_r;
  logic [HW-1:0]         cur_row_r;
  logic [CW-1:0]         cur_col_r;
  logic [PIXEL_BITS-1:0] pix_r;
  logic [RSW-1:0]        row_s_r;
  logic [DWW-1:0]        dest_w_r;
  logic [DWW-1:0]        col_s_r;
  logic [ADDR_W-1:0]     row_base_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [SW-1:0]         rep_r_r;
  logic [SW-1:0]         rep_c_r;

  logic [HW-1:0] adj_row, row_inc, nxt_row;
  logic [CW-1:0] adj_col, col_inc, nxt_col;
  logic [SW-1:0] s_max;
  logic          col_end;
  logic [PW-1:0] base_full;

  // wrap a stale position, then advance past the current pixel
  always_comb begin
    adj_col = src_col_r;
    adj_row = src_row_r;
    if (src_col_r >= width_eff) begin
      adj_col = '0;
      adj_row = src_row_r + HW'(1);
    end
    if (adj_row >= height_eff) adj_row = '0;

    col_inc = adj_col + CW'(1);
    row_inc = adj_row + HW'(1);
    nxt_col = col_inc;
    nxt_row = adj_row;
    if (col_inc >= width_eff) begin
      nxt_col = '0;
      nxt_row = (row_inc >= height_eff) ? '0 : row_inc;
    end
  end

  assign s_max     = scale_eff - SW'(1);
  assign col_end   = (rep_c_r == s_max);
  assign base_full = PW'(row_s_r) * PW'(dest_w_r) + PW'(col_s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_row_r <= '0;
      src_col_r <= '0;
    end else if (cmd.load) begin
      src_row_r <= nxt_row;
      src_col_r <= nxt_col;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_row_r <= adj_row;
      cur_col_r <= adj_col;
      pix_r     <= pixel_in;
    end
    if (cmd.mul) begin
      row_s_r  <= RSW'(cur_row_r) * RSW'(scale_eff);
      dest_w_r <= DWW'(width_eff) * DWW'(scale_eff);
      col_s_r  <= DWW'(cur_col_r) * DWW'(scale_eff);
    end
    if (cmd.base) begin
      row_base_r <= ADDR_W'(base_full);
      addr_r     <= ADDR_W'(base_full);
      rep_r_r    <= '0;
      rep_c_r    <= '0;
    end else if (cmd.step) begin
      if (col_end) begin
        rep_c_r    <= '0;
        rep_r_r    <= rep_r_r + SW'(1);
        row_base_r <= row_base_r + ADDR_W'(dest_w_r);
        addr_r     <= row_base_r + ADDR_W'(dest_w_r);
      end else begin
        rep_c_r <= rep_c_r + SW'(1);
        addr_r  <= addr_r + ADDR_W'(1);
      end
    end
  end

  assign last_of_run = col_end && (rep_r_r == s_max);
  assign sts.last    = last_of_run;
  assign dest_addr   = addr_r;
  assign pixel_out   = pix_r;

endmodule
`default_nettype wire
